// File: rtl/udg_pkg.sv
// Shared types, constants and CRC function for the UART register datagram engine.
package udg_pkg;

    localparam int unsigned ECHO_BYTES  = 4;
    localparam int unsigned REPLY_BYTES = 8;
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned QPTR_W      = $clog2(QDEPTH);
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] SYNC_RESET  = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] REPLY_NODE  = 8'hFF;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC      = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  node;
        logic [6:0]  reg_index;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        reply_done;
        logic [1:0]  reply_status;
        logic [31:0] reply_value;
    } t_out_item;

    typedef struct packed {
        logic        is_reply;
        logic        is_write;
        logic [7:0]  sync_byte;
        logic [7:0]  node;
        logic [7:0]  index_byte;
        logic [1:0]  status;
        logic [31:0] value;
    } t_cmd;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[7] ^ data[i]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/udg_fifo.sv
// Command queue between the classifying front end and the byte serializer.
module udg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  udg_pkg::t_cmd i_push_data,
    output logic          o_full,
    output logic          o_valid,
    output udg_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import udg_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// File: rtl/udg_front.sv
// Front end: accepts items, tracks the read reply and queues datagram or reply commands.
module udg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  udg_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  logic [7:0]        i_sync_byte,
    input  logic              i_full,
    output logic              o_push,
    output udg_pkg::t_cmd     o_push_data
);
    import udg_pkg::*;

    logic        r_pending, n_pending;
    logic [6:0]  r_pend_index, n_pend_index;
    logic [3:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_crc, n_rx_crc;
    logic [7:0]  r_node_byte, n_node_byte;
    logic [7:0]  r_index_byte, n_index_byte;
    logic [31:0] r_shift, n_shift;
    logic        accept;
    logic [3:0]  pos;
    logic [1:0]  status;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign pos        = r_rx_count - 4'(ECHO_BYTES);

    always_comb begin
        if (r_rx_crc != i_in_data.rx_byte) begin
            status = ST_CRC;
        end else if (r_node_byte != REPLY_NODE || r_index_byte[6:0] != r_pend_index) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_pending    = r_pending;
        n_pend_index = r_pend_index;
        n_rx_count   = r_rx_count;
        n_rx_crc     = r_rx_crc;
        n_node_byte  = r_node_byte;
        n_index_byte = r_index_byte;
        n_shift      = r_shift;
        o_push       = 1'b0;
        o_push_data  = '{
            is_reply:   1'b0,
            is_write:   1'b0,
            sync_byte:  i_sync_byte,
            node:       i_in_data.node,
            index_byte: {1'b0, i_in_data.reg_index},
            status:     ST_OK,
            value:      i_in_data.write_value
        };
        if (accept) begin
            unique case (i_in_data.operation)
                OP_WRITE: begin
                    n_pending              = 1'b0;
                    n_rx_count             = '0;
                    o_push                 = 1'b1;
                    o_push_data.is_write   = 1'b1;
                    o_push_data.index_byte = WRITE_FLAG | {1'b0, i_in_data.reg_index};
                end
                OP_READ: begin
                    n_pending    = 1'b1;
                    n_pend_index = i_in_data.reg_index;
                    n_rx_count   = '0;
                    n_rx_crc     = '0;
                    n_node_byte  = '0;
                    n_index_byte = '0;
                    n_shift      = '0;
                    o_push       = 1'b1;
                end
                OP_RX: begin
                    if (r_pending) begin
                        if (r_rx_count < 4'(ECHO_BYTES)) begin
                            n_rx_count = r_rx_count + 1'b1;
                        end else if (pos < 4'(REPLY_BYTES - 1)) begin
                            n_rx_crc   = crc8_byte(r_rx_crc, i_in_data.rx_byte);
                            n_rx_count = r_rx_count + 1'b1;
                            if (pos == 4'd1) begin
                                n_node_byte = i_in_data.rx_byte;
                            end else if (pos == 4'd2) begin
                                n_index_byte = i_in_data.rx_byte;
                            end else if (pos >= 4'd3) begin
                                n_shift = {r_shift[23:0], i_in_data.rx_byte};
                            end
                        end else begin
                            n_pending            = 1'b0;
                            n_rx_count           = '0;
                            o_push               = 1'b1;
                            o_push_data.is_reply = 1'b1;
                            o_push_data.status   = status;
                            o_push_data.value    = r_shift;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_pend_index <= '0;
            r_rx_count   <= '0;
            r_rx_crc     <= '0;
            r_node_byte  <= '0;
            r_index_byte <= '0;
            r_shift      <= '0;
        end else begin
            r_pending    <= n_pending;
            r_pend_index <= n_pend_index;
            r_rx_count   <= n_rx_count;
            r_rx_crc     <= n_rx_crc;
            r_node_byte  <= n_node_byte;
            r_index_byte <= n_index_byte;
            r_shift      <= n_shift;
        end
    end

`ifndef ASSERT_OFF
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_rx_count == '0))
        else $error("reply byte count without pending read");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("command pushed into full queue");
`endif

endmodule

// File: rtl/udg_back.sv
// Back end: serializes queued commands into output items with running CRC.
module udg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  udg_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output udg_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import udg_pkg::*;

    t_cmd      r_cmd;
    logic      r_active, n_active;
    logic [2:0] r_pos, n_pos;
    logic [7:0] r_crc, n_crc;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      can_adv;
    logic      at_last;
    logic      finishing;
    logic      load;
    logic [7:0] sel_byte;

    assign can_adv   = !r_out_valid || !i_out_stall;
    assign at_last   = r_cmd.is_write ? (r_pos == 3'd7) : (r_pos == 3'd3);
    assign finishing = r_active && can_adv && (r_cmd.is_reply || at_last);
    assign load      = i_cmd_valid && (!r_active || finishing);
    assign o_pop     = load;

    always_comb begin
        unique case (r_pos)
            3'd0:    sel_byte = r_cmd.sync_byte;
            3'd1:    sel_byte = r_cmd.node;
            3'd2:    sel_byte = r_cmd.index_byte;
            3'd3:    sel_byte = r_cmd.value[31:24];
            3'd4:    sel_byte = r_cmd.value[23:16];
            3'd5:    sel_byte = r_cmd.value[15:8];
            3'd6:    sel_byte = r_cmd.value[7:0];
            default: sel_byte = r_crc;
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (can_adv) begin
            n_out_valid = r_active;
            if (r_cmd.is_reply) begin
                n_out = '{
                    tx_valid:     1'b0,
                    tx_byte:      8'd0,
                    tx_last:      1'b0,
                    reply_done:   1'b1,
                    reply_status: r_cmd.status,
                    reply_value:  r_cmd.value
                };
            end else begin
                n_out = '{
                    tx_valid:     1'b1,
                    tx_byte:      at_last ? r_crc : sel_byte,
                    tx_last:      at_last,
                    reply_done:   1'b0,
                    reply_status: ST_OK,
                    reply_value:  32'd0
                };
            end
            if (r_active) begin
                n_pos = r_pos + 1'b1;
                n_crc = crc8_byte(r_crc, sel_byte);
            end
        end
        if (finishing) begin
            n_active = 1'b0;
        end
        if (load) begin
            n_active = 1'b1;
            n_pos    = '0;
            n_crc    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_crc       <= '0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.tx_valid ^ o_out_data.reply_done))
        else $error("result is neither a line byte nor a reply");
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !can_adv) |-> !o_pop)
        else $error("command popped while serializer is held");
`endif

endmodule

// File: rtl/uart_register_datagram_engine_core.sv
// Top level of the UART register datagram engine.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): operation 0 queues an
// 8-byte write datagram, 1 a 4-byte read request, 2 a received line byte.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one line byte per
// transfer, tx_last on the CRC byte; a completed reply check gives one transfer with
// reply_done set, status and assembled value.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the sync byte;
// it is always ready. Write it only while the block is idle (the block never checks).
// Throughput: one input item per cycle while the 4-entry command queue has room;
// output is one transfer per cycle unless the output stalls, so a write datagram
// holds the serializer for 8 transfers and a read request for 4. The serializer and
// its output register set this rate; a command is registered in the queue first.
// Reset (synchronous, active low) clears the queue, any pending read, the output
// valid flag, and restores the sync byte to 0x05.
// A stall on the output holds the current transfer; the queue absorbs new items
// until full, then o_in_stall rises.
module uart_register_datagram_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  udg_pkg::t_in_item           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output udg_pkg::t_out_item          o_out_data,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_valid,
    input  logic [7:0]                  i_cfg_data,
    output logic                        o_cfg_ready
);
    import udg_pkg::*;

    logic [7:0] r_sync_byte;
    logic       full;
    logic       push;
    t_cmd       push_data;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sync_byte <= i_cfg_data;
        end
    end

    udg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_sync_byte (r_sync_byte),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    udg_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (cmd_valid),
        .o_data      (cmd),
        .i_pop       (pop)
    );

    udg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: dv/uart_register_datagram_engine_core_tb.sv
// Self-checking testbench for the UART register datagram engine core: frames, replies, sync byte.
`timescale 1ns / 1ps

module uart_register_datagram_engine_core_tb;
    import udg_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CLK_HALF = 6;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_NODE,
        FAULT_INDEX,
        FAULT_CRC_NODE
    } t_fault;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       o_cfg_ready;

    uart_register_datagram_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // engine state as the checker sees it
    logic [7:0]  m_sync = SYNC_RESET;
    logic        m_read_open = 1'b0;
    logic [6:0]  m_read_index = '0;
    logic [3:0]  m_rx_seen = '0;
    logic [7:0]  m_rx_crc = '0;
    logic [7:0]  m_rep_node = '0;
    logic [7:0]  m_rep_index = '0;
    logic [31:0] m_rep_value = '0;

    t_out_item outputs_due[$];
    t_out_item got_item;
    t_out_item want_item;

    int gap_pct = 0;
    int stall_pct = 0;
    int err_cnt = 0;
    int items_sent = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int replies_seen [3] = '{0, 0, 0};

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ d[0]) begin
                c = (c << 1) ^ 8'h07;
            end else begin
                c = c << 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    function automatic void queue_frame(input logic [7:0] bytes [8], input int len);
        t_out_item o;
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < len - 1; i++) begin
            crc = crc8_next(crc, bytes[i]);
            o = '0;
            o.tx_valid = 1'b1;
            o.tx_byte = bytes[i];
            outputs_due.push_back(o);
        end
        o = '0;
        o.tx_valid = 1'b1;
        o.tx_byte = crc;
        o.tx_last = 1'b1;
        outputs_due.push_back(o);
    endfunction

    function automatic void predict_outputs(input t_in_item it);
        logic [7:0] bytes [8];
        t_out_item o;
        int pos;
        for (int i = 0; i < 8; i++) bytes[i] = 8'h00;
        case (it.operation)
            OP_WRITE: begin
                m_read_open = 1'b0;
                m_rx_seen = '0;
                bytes[0] = m_sync;
                bytes[1] = it.node;
                bytes[2] = {1'b1, it.reg_index};
                bytes[3] = it.write_value[31:24];
                bytes[4] = it.write_value[23:16];
                bytes[5] = it.write_value[15:8];
                bytes[6] = it.write_value[7:0];
                queue_frame(bytes, 8);
            end
            OP_READ: begin
                m_read_open = 1'b1;
                m_read_index = it.reg_index;
                m_rx_seen = '0;
                m_rx_crc = '0;
                m_rep_node = '0;
                m_rep_index = '0;
                m_rep_value = '0;
                bytes[0] = m_sync;
                bytes[1] = it.node;
                bytes[2] = {1'b0, it.reg_index};
                queue_frame(bytes, 4);
            end
            OP_RX: begin
                if (m_read_open) begin
                    pos = int'(m_rx_seen) - int'(ECHO_BYTES);
                    if (pos < 0) begin
                        m_rx_seen = m_rx_seen + 4'd1;
                    end else if (pos < 7) begin
                        m_rx_crc = crc8_next(m_rx_crc, it.rx_byte);
                        if (pos == 1) begin
                            m_rep_node = it.rx_byte;
                        end else if (pos == 2) begin
                            m_rep_index = it.rx_byte;
                        end else if (pos >= 3) begin
                            m_rep_value = {m_rep_value[23:0], it.rx_byte};
                        end
                        m_rx_seen = m_rx_seen + 4'd1;
                    end else begin
                        o = '0;
                        o.reply_done = 1'b1;
                        o.reply_value = m_rep_value;
                        if (m_rx_crc != it.rx_byte) begin
                            o.reply_status = ST_CRC;
                        end else if (m_rep_node != REPLY_NODE
                                || m_rep_index[6:0] != m_read_index) begin
                            o.reply_status = ST_MISMATCH;
                        end else begin
                            o.reply_status = ST_OK;
                        end
                        outputs_due.push_back(o);
                        m_read_open = 1'b0;
                        m_rx_seen = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_item = o_out_data;
            results_seen++;
            if (got_item.tx_last) frames_seen++;
            if (got_item.reply_done && got_item.reply_status < 3) begin
                replies_seen[got_item.reply_status]++;
            end
            if (outputs_due.size() == 0) begin
                report_error($sformatf("unexpected transfer %p", got_item));
            end else begin
                want_item = outputs_due.pop_front();
                if (got_item.tx_valid !== want_item.tx_valid
                        || got_item.tx_byte !== want_item.tx_byte
                        || got_item.tx_last !== want_item.tx_last
                        || got_item.reply_done !== want_item.reply_done
                        || got_item.reply_status !== want_item.reply_status
                        || got_item.reply_value !== want_item.reply_value) begin
                    report_error({
                        $sformatf("transfer %0d: expected v=%0b b=%02h l=%0b d=%0b s=%0d val=%08h",
                            results_seen, want_item.tx_valid, want_item.tx_byte,
                            want_item.tx_last, want_item.reply_done,
                            want_item.reply_status, want_item.reply_value),
                        $sformatf(", got v=%0b b=%02h l=%0b d=%0b s=%0d val=%08h",
                            got_item.tx_valid, got_item.tx_byte, got_item.tx_last,
                            got_item.reply_done, got_item.reply_status,
                            got_item.reply_value)});
                end
            end
        end
    end

    function automatic t_in_item rand_item(input logic [1:0] op);
        t_in_item it;
        it.operation = op;
        it.node = 8'($urandom());
        it.reg_index = 7'($urandom());
        it.write_value = $urandom();
        it.rx_byte = 8'($urandom());
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_outputs(it);
        items_sent++;
    endtask

    task automatic push_rx(input logic [7:0] b);
        t_in_item it;
        it = rand_item(OP_RX);
        it.rx_byte = b;
        push_item(it);
    endtask

    // hold the sender until every expected transfer is out, then let the pipe go quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        m_sync = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_read_reply(input t_fault fault, input logic [31:0] value);
        t_in_item it;
        logic [6:0] idx;
        logic [7:0] rb [8];
        logic [7:0] crc;
        idx = 7'($urandom());
        it = rand_item(OP_READ);
        it.reg_index = idx;
        push_item(it);
        for (int k = 0; k < ECHO_BYTES; k++) push_rx(8'($urandom()));
        rb[0] = 8'($urandom());
        rb[1] = (fault == FAULT_NODE || fault == FAULT_CRC_NODE) ?
                8'($urandom_range(254)) : REPLY_NODE;
        rb[2] = {1'($urandom()), idx};
        if (fault == FAULT_INDEX) rb[2][6:0] = idx ^ 7'($urandom_range(127, 1));
        rb[3] = value[31:24];
        rb[4] = value[23:16];
        rb[5] = value[15:8];
        rb[6] = value[7:0];
        crc = 8'h00;
        for (int k = 0; k < 7; k++) crc = crc8_next(crc, rb[k]);
        rb[7] = (fault == FAULT_CRC || fault == FAULT_CRC_NODE) ?
                crc ^ 8'($urandom_range(255, 1)) : crc;
        for (int k = 0; k < 8; k++) push_rx(rb[k]);
    endtask

    task automatic test_datagram_frames();
        t_in_item it;
        it = rand_item(OP_WRITE);
        it.node = 8'h00;
        it.reg_index = 7'h00;
        it.write_value = 32'h0000_0000;
        push_item(it);
        it.node = 8'hFF;
        it.reg_index = 7'h7F;
        it.write_value = 32'hFFFF_FFFF;
        push_item(it);
        push_item(rand_item(OP_WRITE));
        push_rx(8'hFF);
        push_rx(8'h00);
        push_item(rand_item(OP_NONE));
        it = rand_item(OP_READ);
        it.node = 8'h00;
        it.reg_index = 7'h00;
        push_item(it);
        it.node = 8'hFF;
        it.reg_index = 7'h7F;
        push_item(it);
        push_item(rand_item(OP_WRITE));
    endtask

    task automatic test_pending_overrides();
        t_in_item it;
        push_item(rand_item(OP_READ));
        repeat (3) push_rx(8'($urandom()));
        push_item(rand_item(OP_WRITE));
        repeat (12) push_rx(8'($urandom()));
        push_item(rand_item(OP_READ));
        repeat (6) push_rx(8'($urandom()));
        push_item(rand_item(OP_NONE));
        run_read_reply(FAULT_NONE, $urandom());
    endtask

    task automatic test_reply_checks();
        run_read_reply(FAULT_NONE, 32'h0000_0000);
        run_read_reply(FAULT_NONE, 32'hFFFF_FFFF);
        settle();
        run_read_reply(FAULT_CRC, $urandom());
        run_read_reply(FAULT_NODE, $urandom());
        run_read_reply(FAULT_INDEX, $urandom());
        run_read_reply(FAULT_CRC_NODE, $urandom());
    endtask

    task automatic test_mixed_traffic(input int quota);
        int sent;
        int pick;
        int cut;
        t_fault fault;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                fault = ($urandom_range(1) == 0) ? FAULT_NONE : t_fault'($urandom_range(4, 1));
                run_read_reply(fault, $urandom());
                sent += 13;
            end else if (pick < 75) begin
                push_item(rand_item(OP_WRITE));
                sent++;
            end else if (pick < 87) begin
                push_item(rand_item(OP_READ));
                cut = $urandom_range(11);
                for (int k = 0; k < cut; k++) push_rx(8'($urandom()));
                sent += 1 + cut;
            end else if (pick < 95) begin
                push_rx(8'($urandom()));
                sent++;
            end else begin
                push_item(rand_item(OP_NONE));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct = 20;
        stall_pct = 66;
        test_datagram_frames();
        write_sync(8'h00);
        test_pending_overrides();
        test_reply_checks();
        test_mixed_traffic(25);

        write_sync(8'hFF);
        gap_pct = 66;
        stall_pct = 20;
        test_mixed_traffic(30);

        write_sync(8'($urandom()));
        gap_pct = 0;
        stall_pct = 0;
        test_mixed_traffic(30);

        settle();
        repeat (20) @(posedge i_clk);
        if (outputs_due.size() != 0) begin
            report_error($sformatf("%0d expected transfers never arrived", outputs_due.size()));
        end
        $display("Sent %0d items, checked %0d transfers in %0d frames and reply reports.",
                 items_sent, results_seen, frames_seen);
        $display("Replies: %0d ok, %0d CRC errors, %0d node/index errors; %0d failures.",
                 replies_seen[0], replies_seen[1], replies_seen[2], err_cnt);
        if (err_cnt == 0) begin
            $display("uart_register_datagram_engine_core_tb: clean");
        end else begin
            $display("uart_register_datagram_engine_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d transfers outstanding", outputs_due.size());
        $display("uart_register_datagram_engine_core_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/udg_pkg.sv
rtl/udg_fifo.sv
rtl/udg_front.sv
rtl/udg_back.sv
rtl/uart_register_datagram_engine_core.sv
dv/uart_register_datagram_engine_core_tb.sv
